/* rtl/column_dedup_compact_defines.svh */
// column_dedup_compact_defines.svh: assertion macros for the column dedup block
// included by the front and back modules; depends on nothing else

`ifndef COLUMN_DEDUP_COMPACT_DEFINES_SVH
`define COLUMN_DEDUP_COMPACT_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define CDEDUP_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cdedup assertion failed");

// next-cycle implication, quiet while reset is high
`define CDEDUP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cdedup assertion failed");

`endif

/* rtl/cdedup_pkg.sv */
// cdedup_pkg: payload types, control struct and default sizes of the column dedup block
// used by the front, back and top modules; depends on nothing

package cdedup_pkg;

   // fixed width of the value fields on both channels
   localparam int FIELD_BITS = 16;

   // defaults for the top level parameters
   localparam int MAX_ROWS_DEFAULT   = 16;
   localparam int VALUE_BITS_DEFAULT = 16;

   // entries in the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // input item
   typedef struct packed {
      logic [FIELD_BITS-1:0] element_value;
      logic                  column_end;
   } req_type;

   // result item
   typedef struct packed {
      logic [FIELD_BITS-1:0] result_value;
      logic                  is_padding;
      logic                  column_done;
   } rsp_type;

   // control part of one queued command
   typedef struct packed {
      logic emit;   // first occurrence to send out
      logic last;   // command closes the column
   } cmd_ctl_type;

endpackage

/* rtl/cdedup_front.sv */
// cdedup_front: accepts elements, compares against the seen values of the column in parallel
// and queues emit / padding commands; depends on cdedup_pkg and the assertion header

`include "column_dedup_compact_defines.svh"

module cdedup_front #(
   parameter int MAX_ROWS   = cdedup_pkg::MAX_ROWS_DEFAULT,
   parameter int VALUE_BITS = cdedup_pkg::VALUE_BITS_DEFAULT,
   localparam int CMP_BITS  = (VALUE_BITS < cdedup_pkg::FIELD_BITS) ?
                              VALUE_BITS : cdedup_pkg::FIELD_BITS,
   localparam int CNT_BITS  = $clog2(MAX_ROWS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cdedup_pkg::req_type   req_data,
   input  logic                  q_full,
   output logic                  q_push,
   output cdedup_pkg::cmd_ctl_type q_ctl,
   output logic [CMP_BITS-1:0]   q_value,
   output logic [CNT_BITS-1:0]   q_pads
);

   localparam int IDX_BITS = $clog2(MAX_ROWS);

   logic [CMP_BITS-1:0] seen_ff [MAX_ROWS];
   logic [CMP_BITS-1:0] seen_in [MAX_ROWS];
   logic [CNT_BITS-1:0] seen_count_ff, seen_count_in;
   logic [CNT_BITS-1:0] drop_count_ff, drop_count_in;

   logic [CMP_BITS-1:0] value;
   logic [MAX_ROWS-1:0] match;
   logic [CNT_BITS:0]   fill;
   logic [CNT_BITS-1:0] drop_next;
   logic                accept, room, hit, emit, dropped;

   // transfer and classification of the element
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign value     = req_data.element_value[CMP_BITS-1:0];
   assign fill      = {1'b0, seen_count_ff} + {1'b0, drop_count_ff};
   assign room      = fill < (CNT_BITS + 1)'(MAX_ROWS);

   // parallel compare against the valid part of the seen list
   always_comb begin
      for (int i = 0; i < MAX_ROWS; i++) begin
         match[i] = (CNT_BITS'(i) < seen_count_ff) && (seen_ff[i] == value);
      end
   end

   assign hit       = |match;
   assign emit      = accept && room && !hit;
   assign dropped   = accept && room && hit;
   assign drop_next = drop_count_ff + CNT_BITS'(dropped);

   // command toward the back part
   assign q_push     = emit || (accept && req_data.column_end && (drop_next != '0));
   assign q_ctl.emit = emit;
   assign q_ctl.last = req_data.column_end;
   assign q_value    = value;
   assign q_pads     = req_data.column_end ? drop_next : '0;

   // next state of the seen list and counters
   always_comb begin
      seen_in       = seen_ff;
      seen_count_in = seen_count_ff;
      drop_count_in = drop_count_ff;
      if (emit) begin
         seen_in[seen_count_ff[IDX_BITS-1:0]] = value;
      end
      if (accept) begin
         if (req_data.column_end) begin
            seen_count_in = '0;
            drop_count_in = '0;
         end else begin
            seen_count_in = seen_count_ff + CNT_BITS'(emit);
            drop_count_in = drop_next;
         end
      end
   end

   // counters
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_count_ff <= '0;
         drop_count_ff <= '0;
      end else begin
         seen_count_ff <= seen_count_in;
         drop_count_ff <= drop_count_in;
      end
   end

   // seen values, valid only below the count
   always_ff @(posedge clock) begin
      seen_ff <= seen_in;
   end

   // checks
   `CDEDUP_ASSERT(a_fill_bound, clock, reset, 1'b1, fill <= (CNT_BITS + 1)'(MAX_ROWS))
   `CDEDUP_ASSERT_NEXT(a_column_clears, clock, reset, accept && req_data.column_end, (seen_count_ff == '0) && (drop_count_ff == '0))

endmodule

/* rtl/cdedup_fifo.sv */
// cdedup_fifo: short register queue of commands between front and back
// generic width and depth; depends on nothing

module cdedup_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/cdedup_back.sv */
// cdedup_back: expands queued commands into result transfers, one per cycle while rsp is not stalled
// holds the output register; depends on cdedup_pkg and the assertion header

`include "column_dedup_compact_defines.svh"

module cdedup_back #(
   parameter int MAX_ROWS   = cdedup_pkg::MAX_ROWS_DEFAULT,
   parameter int VALUE_BITS = cdedup_pkg::VALUE_BITS_DEFAULT,
   localparam int CMP_BITS  = (VALUE_BITS < cdedup_pkg::FIELD_BITS) ?
                              VALUE_BITS : cdedup_pkg::FIELD_BITS,
   localparam int CNT_BITS  = $clog2(MAX_ROWS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   output logic                    q_pop,
   input  cdedup_pkg::cmd_ctl_type q_ctl,
   input  logic [CMP_BITS-1:0]     q_value,
   input  logic [CNT_BITS-1:0]     q_pads,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output cdedup_pkg::rsp_type     rsp_data
);

   localparam int FIELD_BITS = cdedup_pkg::FIELD_BITS;

   logic                cur_valid_ff, cur_valid_in;
   logic                cur_emit_ff, cur_emit_in;
   logic                cur_last_ff, cur_last_in;
   logic [CMP_BITS-1:0] cur_value_ff, cur_value_in;
   logic [CNT_BITS-1:0] cur_pads_ff, cur_pads_in;
   logic                rsp_valid_ff, rsp_valid_in;
   cdedup_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic out_free, gen, finished;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop    = !cur_valid_ff && q_valid;
   assign gen      = cur_valid_ff && out_free;
   assign finished = cur_emit_ff ? (cur_pads_ff == '0) : (cur_pads_ff == CNT_BITS'(1));

   // one result per cycle from the current command while the output is not stalled
   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_emit_in  = cur_emit_ff;
      cur_last_in  = cur_last_ff;
      cur_value_in = cur_value_ff;
      cur_pads_in  = cur_pads_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // load the next command when idle
      if (q_pop) begin
         cur_valid_in = 1'b1;
         cur_emit_in  = q_ctl.emit;
         cur_last_in  = q_ctl.last;
         cur_value_in = q_value;
         cur_pads_in  = q_pads;
      end

      if (out_free) begin
         rsp_valid_in = gen;
      end

      if (gen) begin
         if (cur_emit_ff) begin
            // first occurrence, then any padding
            rsp_data_in.result_value = FIELD_BITS'(cur_value_ff);
            rsp_data_in.is_padding   = 1'b0;
            rsp_data_in.column_done  = cur_last_ff && (cur_pads_ff == '0);
            cur_emit_in              = 1'b0;
         end else begin
            // padding zero
            rsp_data_in.result_value = '0;
            rsp_data_in.is_padding   = 1'b1;
            rsp_data_in.column_done  = cur_last_ff && (cur_pads_ff == CNT_BITS'(1));
            cur_pads_in              = cur_pads_ff - 1'b1;
         end
         if (finished) begin
            cur_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // command and result payload
   always_ff @(posedge clock) begin
      cur_emit_ff  <= cur_emit_in;
      cur_last_ff  <= cur_last_in;
      cur_value_ff <= cur_value_in;
      cur_pads_ff  <= cur_pads_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `CDEDUP_ASSERT_NEXT(a_entry_retires, clock, reset, gen && finished, !cur_valid_ff)
   `CDEDUP_ASSERT(a_pad_entry_nonempty, clock, reset, cur_valid_ff && !cur_emit_ff, cur_pads_ff != '0)

endmodule

/* rtl/column_dedup_compact.sv */
// column_dedup_compact: one element per transfer in; first occurrences out, padding zeros at column end.
// A result passes the command queue, the back's current-command register and its output register.
// Throughput: the front takes one element per cycle while the two-entry command queue has room;
// the back sends one result per cycle while rsp is not stalled, and loads a queued command only
// when it holds none, so it cannot take a new command before it is through with the last one.
// Reset (synchronous): counters, queue, current command and output valid clear; the seen list needs no clearing.

module column_dedup_compact #(
   parameter int MAX_ROWS   = cdedup_pkg::MAX_ROWS_DEFAULT,
   parameter int VALUE_BITS = cdedup_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  cdedup_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output cdedup_pkg::rsp_type rsp_data
);

   localparam int CMP_BITS = (VALUE_BITS < cdedup_pkg::FIELD_BITS) ?
                             VALUE_BITS : cdedup_pkg::FIELD_BITS;
   localparam int CNT_BITS = $clog2(MAX_ROWS + 1);
   localparam int CMD_BITS = $bits(cdedup_pkg::cmd_ctl_type) + CMP_BITS + CNT_BITS;

   logic                    push, full, pop, pop_valid;
   cdedup_pkg::cmd_ctl_type push_ctl, pop_ctl;
   logic [CMP_BITS-1:0]     push_value, pop_value;
   logic [CNT_BITS-1:0]     push_pads, pop_pads;
   logic [CMD_BITS-1:0]     push_cmd, pop_cmd;

   // element classification and seen list
   cdedup_front #(
      .MAX_ROWS   (MAX_ROWS),
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (full),
      .q_push    (push),
      .q_ctl     (push_ctl),
      .q_value   (push_value),
      .q_pads    (push_pads)
   );

   // command queue
   assign push_cmd = {push_ctl, push_value, push_pads};
   assign {pop_ctl, pop_value, pop_pads} = pop_cmd;

   cdedup_fifo #(
      .WIDTH (CMD_BITS),
      .DEPTH (cdedup_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .full      (full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_cmd)
   );

   // result generation and output register
   cdedup_back #(
      .MAX_ROWS   (MAX_ROWS),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (pop_valid),
      .q_pop     (pop),
      .q_ctl     (pop_ctl),
      .q_value   (pop_value),
      .q_pads    (pop_pads),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
